@@ rtl/brld_pkg.sv @@
// Shared constants and types for the byte run-length decoder.
// No dependencies; used by brld_ctrl, brld_datapath and the core.
`timescale 1ns / 1ps

package brld_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;

  localparam logic [BYTE_W-1:0] LITERAL_MAX = 8'd191;
  localparam logic [BYTE_W-1:0] MARKER_MIN  = 8'd192;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 7'd1;

  typedef struct packed {
    logic load_count;
    logic emit_literal;
    logic emit_first;
    logic emit_repeat;
    logic emit_error;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_marker;
    logic count_one;
  } status_t;

endpackage

@@ rtl/brld_datapath.sv @@
// Datapath: run count, held run byte and the output register.
// Depends on brld_pkg; driven by commands from brld_ctrl.
`timescale 1ns / 1ps

module brld_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  brld_pkg::cmd_t              cmd,
  output brld_pkg::status_t           status,
  input  logic [brld_pkg::BYTE_W-1:0] in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [brld_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last,
  output logic                        out_err
);

  logic [brld_pkg::COUNT_W-1:0] count;
  logic [brld_pkg::BYTE_W-1:0]  run_byte;
  logic [brld_pkg::BYTE_W-1:0]  count_diff;
  logic                         emit_any;

  assign count_diff = in_byte - brld_pkg::LITERAL_MAX;
  assign emit_any   = cmd.emit_literal | cmd.emit_first | cmd.emit_repeat | cmd.emit_error;

  assign status.out_free  = ~out_valid | out_ready;
  assign status.is_marker = in_byte >= brld_pkg::MARKER_MIN;
  assign status.count_one = count == brld_pkg::COUNT_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_count) begin
      count <= count_diff[brld_pkg::COUNT_W-1:0];
    end else if (cmd.emit_first || cmd.emit_repeat) begin
      count <= count - brld_pkg::COUNT_ONE;
    end
    if (cmd.emit_first) begin
      run_byte <= in_byte;
    end
    if (cmd.emit_literal) begin
      out_byte <= in_byte;
      out_last <= 1'b1;
      out_err  <= 1'b0;
    end else if (cmd.emit_first) begin
      out_byte <= in_byte;
      out_last <= status.count_one;
      out_err  <= 1'b0;
    end else if (cmd.emit_repeat) begin
      out_byte <= run_byte;
      out_last <= status.count_one;
      out_err  <= 1'b0;
    end else if (cmd.emit_error) begin
      out_byte <= '0;
      out_last <= 1'b1;
      out_err  <= 1'b1;
    end
  end

endmodule

@@ rtl/brld_ctrl.sv @@
// Controller: tracks idle, marker seen and run repeat phases.
// Depends on brld_pkg; issues commands to brld_datapath.
`timescale 1ns / 1ps

module brld_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_eos,
  input  brld_pkg::status_t   status,
  output brld_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARKED,
    ST_REPEAT
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = (state != ST_REPEAT) && status.out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          if (status.is_marker && in_eos) begin
            cmd.emit_error = 1'b1;
          end else if (status.is_marker) begin
            cmd.load_count = 1'b1;
            state_next     = ST_MARKED;
          end else begin
            cmd.emit_literal = 1'b1;
          end
        end
      end
      ST_MARKED: begin
        if (take) begin
          cmd.emit_first = 1'b1;
          state_next     = status.count_one ? ST_IDLE : ST_REPEAT;
        end
      end
      ST_REPEAT: begin
        if (status.out_free) begin
          cmd.emit_repeat = 1'b1;
          if (status.count_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/byte_run_length_decoder_core.sv @@
// Byte run-length decoder core: the result is registered and shows in the cycle after the input transfer.
// A literal or error gives one result; a marker gives nothing and loads the count;
// the run byte after it gives count copies while the input is held, one copy per cycle while the output is free.
// Throughput is one result per cycle while m_tready is high, bound by the single output register.
// Reset (rst, synchronous) returns to idle with no pending run and no result.
// Depends on brld_pkg, brld_ctrl and brld_datapath.
`timescale 1ns / 1ps

module byte_run_length_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last_of_run
  output logic       m_tuser    // [0] truncated_error
);

  brld_pkg::cmd_t    cmd;
  brld_pkg::status_t status;

  brld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_eos   (s_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  brld_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

endmodule
